// ===== src/ami_pkg.sv =====
// ----------------------------------------------------------------------------
// ami_pkg
// Shared constants, widths and word types of the affine 3x4 inverse pipeline.
// ----------------------------------------------------------------------------
package ami_pkg;

  // fraction bits of every entry, Q16.16 by default (8 to 24 allowed)
  localparam int FRAC_BITS = 16;

  localparam int IN_W     = 32;                 // one matrix entry
  localparam int NUM_ENT  = 12;                 // entries of a 3x4 matrix
  localparam int NUM_COF  = 9;                  // cofactors of the 3x3 part
  localparam int NUM_PROD = 2 * NUM_COF;        // products feeding the cofactors
  localparam int NUM_TERM = 12;                 // determinant and offset terms
  localparam int NUM_LANE = 4;                  // three columns plus offset
  localparam int PROD_W   = 2 * IN_W;           // entry times entry
  localparam int COF_W    = PROD_W + 1;         // difference of two products
  localparam int SPLIT_W  = 32;                 // low slice of a split cofactor
  localparam int PP_W     = COF_W;              // partial product width
  localparam int MP_W     = 96;                 // entry times cofactor
  localparam int SUM_W    = MP_W + 1;           // sum of three such terms
  localparam int D_MAG_W  = MP_W;               // determinant magnitude
  localparam int REM_W    = D_MAG_W + 1;        // twice the determinant magnitude
  localparam int Q_W      = 32;                 // quotient bits per result
  localparam int N_MAG_W  = MP_W + FRAC_BITS;   // scaled numerator magnitude
  localparam int N2_W     = N_MAG_W + 2;        // 2*|num| + |den|
  localparam int HI_W     = N2_W - Q_W;         // part above the quotient bits

  // row codes
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_MID   = 2'd1;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  // saturation limits
  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  // operand pairs (row*4+col) of each cofactor: p*q - s*t
  localparam logic [3:0] COF_IDX [NUM_COF][4] = '{
    '{4'd5,  4'd10, 4'd6,  4'd9},
    '{4'd9,  4'd2,  4'd10, 4'd1},
    '{4'd1,  4'd6,  4'd2,  4'd5},
    '{4'd6,  4'd8,  4'd4,  4'd10},
    '{4'd10, 4'd0,  4'd8,  4'd2},
    '{4'd2,  4'd4,  4'd0,  4'd6},
    '{4'd4,  4'd9,  4'd5,  4'd8},
    '{4'd8,  4'd1,  4'd9,  4'd0},
    '{4'd0,  4'd5,  4'd1,  4'd4}
  };

  typedef logic [NUM_ENT-1:0][IN_W-1:0] mat_t;

  typedef struct packed {
    mat_t                           mat;
    logic [NUM_COF-1:0][COF_W-1:0]  cof;
  } cof_word_t;

  typedef struct packed {
    logic [NUM_COF-1:0][COF_W-1:0]  cof;
    logic [SUM_W-1:0]               det;
    logic [2:0][SUM_W-1:0]          osum;
  } sums_word_t;

  typedef struct packed {
    logic [1:0] row_index;
    logic       singular;
    logic       last_row;
  } side_t;

  typedef struct packed {
    logic [2:0][COF_W-1:0] cnum;
    logic [SUM_W-1:0]      onum;
    logic [SUM_W-1:0]      det;
    side_t                 side;
  } row_word_t;

  typedef struct packed {
    side_t                        side;
    logic [NUM_LANE-1:0][Q_W-1:0] val;
  } res_word_t;

endpackage

// ===== src/ami_in_if.sv =====
// ----------------------------------------------------------------------------
// ami_in_if
// Matrix channel: valid/ready handshake and the twelve entries of one matrix.
// ----------------------------------------------------------------------------
interface ami_in_if import ami_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] a00, a01, a02, a03;
  logic signed [IN_W-1:0] a10, a11, a12, a13;
  logic signed [IN_W-1:0] a20, a21, a22, a23;

  modport source (
    output valid, a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23,
    input  ready
  );
  modport sink (
    input  valid, a00, a01, a02, a03, a10, a11, a12, a13, a20, a21, a22, a23,
    output ready
  );
endinterface

// ===== src/ami_out_if.sv =====
// ----------------------------------------------------------------------------
// ami_out_if
// Result channel: valid/ready handshake and one row of the inverse.
// ----------------------------------------------------------------------------
interface ami_out_if import ami_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            row_index;
  logic signed [Q_W-1:0] col0, col1, col2, offset;
  logic                  singular;
  logic                  last_row;

  modport source (
    output valid, row_index, col0, col1, col2, offset, singular, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, offset, singular, last_row,
    output ready
  );
endinterface

// ===== src/ami_cofactor.sv =====
// ----------------------------------------------------------------------------
// ami_cofactor
// Three-stage front end: input register, 18 entry products, 9 cofactors.
// ----------------------------------------------------------------------------
module ami_cofactor import ami_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  mat_t      in_mat,
  output logic      out_valid,
  input  logic      out_ready,
  output cof_word_t out_word
);

  logic                           v1, v2, v3;
  logic                           en;
  mat_t                           a1, a2;
  logic [NUM_PROD-1:0][PROD_W-1:0] p2;

  // whole pipe moves when the last stage is empty or drained
  assign en        = !v3 || out_ready;
  assign in_ready  = en;
  assign out_valid = v3;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // input register, products, cofactor differences
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= in_mat;
      a2 <= a1;
      for (int i = 0; i < NUM_COF; i++) begin
        p2[2*i]   <= $signed(a1[COF_IDX[i][0]]) * $signed(a1[COF_IDX[i][1]]);
        p2[2*i+1] <= $signed(a1[COF_IDX[i][2]]) * $signed(a1[COF_IDX[i][3]]);
      end
      out_word.mat <= a2;
      for (int i = 0; i < NUM_COF; i++) begin
        out_word.cof[i] <= COF_W'($signed(p2[2*i])) - COF_W'($signed(p2[2*i+1]));
      end
    end
  end

endmodule

// ===== src/ami_accum.sv =====
// ----------------------------------------------------------------------------
// ami_accum
// Determinant and translation sums: split partial products, product merge,
// and three-term sums, one register stage each.
// ----------------------------------------------------------------------------
module ami_accum import ami_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cof_word_t  in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output sums_word_t out_word
);

  logic                              v4, v5, v6;
  logic                              en;
  logic [NUM_TERM-1:0][IN_W-1:0]     tm;
  logic [NUM_TERM-1:0][COF_W-1:0]    tc;
  logic [NUM_TERM-1:0][PP_W-1:0]     lo4, hi4;
  logic [NUM_TERM-1:0][MP_W-1:0]     prod5;
  logic [NUM_COF-1:0][COF_W-1:0]     cof4, cof5;

  assign en        = !v6 || out_ready;
  assign in_ready  = en;
  assign out_valid = v6;

  // operand pairs: row 0 times first adjugate column, then translations
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tm[k] = in_word.mat[k];
      tc[k] = in_word.cof[3*k];
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        tm[3+3*r+k] = in_word.mat[4*k+3];
        tc[3+3*r+k] = in_word.cof[3*r+k];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // partial products, merge, three-term sums
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_TERM; j++) begin
        lo4[j] <= $signed(tm[j]) * $signed({1'b0, tc[j][SPLIT_W-1:0]});
        hi4[j] <= $signed(tm[j]) * $signed(tc[j][COF_W-1:SPLIT_W]);
      end
      cof4 <= in_word.cof;

      for (int j = 0; j < NUM_TERM; j++) begin
        prod5[j] <= {hi4[j][MP_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}}
                    + MP_W'($signed(lo4[j]));
      end
      cof5 <= cof4;

      out_word.det <= SUM_W'($signed(prod5[0])) + SUM_W'($signed(prod5[1]))
                      + SUM_W'($signed(prod5[2]));
      for (int r = 0; r < 3; r++) begin
        out_word.osum[r] <= SUM_W'($signed(prod5[3+3*r])) + SUM_W'($signed(prod5[4+3*r]))
                            + SUM_W'($signed(prod5[5+3*r]));
      end
      out_word.cof <= cof5;
    end
  end

endmodule

// ===== src/ami_row_seq.sv =====
// ----------------------------------------------------------------------------
// ami_row_seq
// Holds one matrix worth of sums and hands out its three rows, one per word.
// ----------------------------------------------------------------------------
module ami_row_seq import ami_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sums_word_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output row_word_t  out_word
);

  logic       hv;
  logic [1:0] row;
  sums_word_t hd;

  assign in_ready  = !hv || (out_ready && row == ROW_LAST);
  assign out_valid = hv;

  // row select
  always_comb begin
    out_word.det            = hd.det;
    out_word.side.row_index = row;
    out_word.side.singular  = (hd.det == '0);
    out_word.side.last_row  = (row == ROW_LAST);
    case (row)
      ROW_FIRST: begin
        out_word.cnum = {hd.cof[2], hd.cof[1], hd.cof[0]};
        out_word.onum = hd.osum[0];
      end
      ROW_MID: begin
        out_word.cnum = {hd.cof[5], hd.cof[4], hd.cof[3]};
        out_word.onum = hd.osum[1];
      end
      ROW_LAST: begin
        out_word.cnum = {hd.cof[8], hd.cof[7], hd.cof[6]};
        out_word.onum = hd.osum[2];
      end
      default: begin
        out_word.cnum = '0;
        out_word.onum = '0;
      end
    endcase
  end

  // hold register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hv  <= 1'b0;
      row <= ROW_FIRST;
    end else if (in_ready) begin
      hv  <= in_valid;
      row <= ROW_FIRST;
    end else if (out_ready) begin
      row <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hd <= in_word;
    end
  end

endmodule

// ===== src/ami_rdiv.sv =====
// ----------------------------------------------------------------------------
// ami_rdiv
// Four-lane pipelined rounding divider: scaled cofactors and offset over the
// determinant, one quotient bit per stage, saturation, two-word output skid.
// ----------------------------------------------------------------------------
module ami_rdiv import ami_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  row_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output res_word_t out_word
);

  typedef struct packed {
    logic [NUM_LANE-1:0][N_MAG_W-1:0] nmag;
    logic [D_MAG_W-1:0]               dmag;
    logic [NUM_LANE-1:0]              neg;
    side_t                            side;
  } pre_t;

  typedef struct packed {
    logic [NUM_LANE-1:0][N2_W-1:0] n2;
    logic [REM_W-1:0]              d2;
    logic [NUM_LANE-1:0]           neg;
    side_t                         side;
  } nd_t;

  typedef struct packed {
    logic [NUM_LANE-1:0][REM_W-1:0] rem;
    logic [NUM_LANE-1:0][Q_W-1:0]   low;
    logic [NUM_LANE-1:0][Q_W-1:0]   q;
    logic [NUM_LANE-1:0]            ovf;
    logic [NUM_LANE-1:0]            neg;
    logic [REM_W-1:0]               d2;
    side_t                          side;
  } step_t;

  // one restoring step in every lane
  function automatic step_t div_step(step_t s);
    step_t          r;
    logic [REM_W:0] rp;
    logic [REM_W:0] diff;
    logic           ge;
    r = s;
    for (int l = 0; l < NUM_LANE; l++) begin
      rp   = {s.rem[l], s.low[l][Q_W-1]};
      diff = rp - {1'b0, s.d2};
      ge   = (rp >= {1'b0, s.d2});
      r.rem[l] = ge ? diff[REM_W-1:0] : rp[REM_W-1:0];
      r.low[l] = {s.low[l][Q_W-2:0], 1'b0};
      r.q[l]   = {s.q[l][Q_W-2:0], ge};
    end
    return r;
  endfunction

  logic                   en;
  logic                   v_p0, v_p1;
  logic [Q_W:0]           v_st;
  pre_t                   p0, p0_next;
  nd_t                    p1;
  step_t                  st [Q_W+1];
  step_t                  st0_next;
  res_word_t              fin;
  res_word_t              sk [2];
  logic                   wp, rp;
  logic [1:0]             cnt;
  logic                   push, pop;

  assign en       = (cnt != 2'd2);
  assign in_ready = en;
  assign push     = en && v_st[Q_W];
  assign pop      = out_valid && out_ready;

  // signs and scaled magnitudes
  always_comb begin
    logic [COF_W-1:0] cabs;
    logic [SUM_W-1:0] sabs;
    logic [SUM_W-1:0] dabs;
    logic             dneg;
    dneg = in_word.det[SUM_W-1];
    dabs = dneg ? (SUM_W'(0) - in_word.det) : in_word.det;
    p0_next.dmag = dabs[D_MAG_W-1:0];
    p0_next.side = in_word.side;
    for (int k = 0; k < 3; k++) begin
      cabs = in_word.cnum[k][COF_W-1] ? (COF_W'(0) - in_word.cnum[k]) : in_word.cnum[k];
      p0_next.nmag[k] = N_MAG_W'(cabs[PROD_W-1:0]) << (2 * FRAC_BITS);
      p0_next.neg[k]  = in_word.cnum[k][COF_W-1] ^ dneg;
    end
    // offset is minus the translation sum
    sabs = in_word.onum[SUM_W-1] ? (SUM_W'(0) - in_word.onum) : in_word.onum;
    p0_next.nmag[3] = N_MAG_W'(sabs[MP_W-1:0]) << FRAC_BITS;
    p0_next.neg[3]  = !in_word.onum[SUM_W-1] ^ dneg;
  end

  // overflow check and first remainder
  always_comb begin
    logic [HI_W-1:0] hi;
    st0_next.d2   = p1.d2;
    st0_next.neg  = p1.neg;
    st0_next.side = p1.side;
    for (int l = 0; l < NUM_LANE; l++) begin
      hi = p1.n2[l][N2_W-1:Q_W];
      st0_next.rem[l] = REM_W'(hi);
      st0_next.ovf[l] = (REM_W'(hi) >= p1.d2);
      st0_next.low[l] = p1.n2[l][Q_W-1:0];
      st0_next.q[l]   = '0;
    end
  end

  // sign, saturation, singular zeroing
  always_comb begin
    fin.side = st[Q_W].side;
    for (int l = 0; l < NUM_LANE; l++) begin
      if (st[Q_W].side.singular) begin
        fin.val[l] = '0;
      end else if (st[Q_W].neg[l]) begin
        fin.val[l] = (st[Q_W].ovf[l] || st[Q_W].q[l] > SAT_NEG) ? SAT_NEG
                     : (Q_W'(0) - st[Q_W].q[l]);
      end else begin
        fin.val[l] = (st[Q_W].ovf[l] || st[Q_W].q[l] > SAT_POS) ? SAT_POS
                     : st[Q_W].q[l];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v_p0 <= 1'b0;
      v_p1 <= 1'b0;
      v_st <= '0;
    end else if (en) begin
      v_p0 <= in_valid;
      v_p1 <= v_p0;
      v_st <= {v_st[Q_W-1:0], v_p1};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= p0_next;
      for (int l = 0; l < NUM_LANE; l++) begin
        p1.n2[l] <= N2_W'({p0.nmag[l], 1'b0}) + N2_W'(p0.dmag);
      end
      p1.d2   <= {p0.dmag, 1'b0};
      p1.neg  <= p0.neg;
      p1.side <= p0.side;
      st[0]   <= st0_next;
      for (int s = 1; s <= Q_W; s++) begin
        st[s] <= div_step(st[s-1]);
      end
    end
  end

  // output skid
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sk[wp] <= fin;
    end
  end

  assign out_valid = (cnt != 2'd0);
  assign out_word  = sk[rp];

endmodule

// ===== src/affine_matrix_inverse_3x4_top.sv =====
// ----------------------------------------------------------------------------
// affine_matrix_inverse_3x4_top
// Affine inverse of a 3x4 Q16.16 matrix, returned as three row words.
// ----------------------------------------------------------------------------
// One matrix word in gives three result words out, rows 0, 1, 2 in order,
// last_row marking row 2. The row hold takes a new matrix once its last
// row has gone on, and the divider takes one row per cycle while its output
// skid is not full, serving all four entries of a row at once. From matrix
// to first row a word passes the cofactor stages, the determinant and
// translation sum stages, the row hold, 35 divider stages (two setup
// stages, the overflow check, then one quotient bit each for 32 stages) and
// the output skid. Entries are rounded to nearest, halves away from zero,
// and saturated; a zero determinant gives zero rows with singular set.
module affine_matrix_inverse_3x4_top import ami_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ami_in_if.sink   matrix,
  ami_out_if.source result
);

  mat_t       in_mat;
  logic       cof_valid, cof_ready;
  cof_word_t  cof_word;
  logic       sum_valid, sum_ready;
  sums_word_t sum_word;
  logic       row_valid, row_ready;
  row_word_t  row_word;
  res_word_t  res_word;

  // entries in row-major order
  assign in_mat = {matrix.a23, matrix.a22, matrix.a21, matrix.a20,
                   matrix.a13, matrix.a12, matrix.a11, matrix.a10,
                   matrix.a03, matrix.a02, matrix.a01, matrix.a00};

  ami_cofactor u_cofactor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (matrix.valid),
    .in_ready  (matrix.ready),
    .in_mat    (in_mat),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .out_word  (cof_word)
  );

  ami_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .in_word   (cof_word),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_word  (sum_word)
  );

  ami_row_seq u_row_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_word   (sum_word),
    .out_valid (row_valid),
    .out_ready (row_ready),
    .out_word  (row_word)
  );

  ami_rdiv u_rdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_valid),
    .in_ready  (row_ready),
    .in_word   (row_word),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_word  (res_word)
  );

  // result word fields
  assign result.row_index = res_word.side.row_index;
  assign result.singular  = res_word.side.singular;
  assign result.last_row  = res_word.side.last_row;
  assign result.col0      = res_word.val[0];
  assign result.col1      = res_word.val[1];
  assign result.col2      = res_word.val[2];
  assign result.offset    = res_word.val[3];

endmodule

// ===== tb/sv/affine_matrix_inverse_3x4_top_test.sv =====
// ----------------------------------------------------------------------------
// affine_matrix_inverse_3x4_top_test
// Self-checking bench for the affine 3x4 inverse: matrix words are driven
// from a queue, each accepted matrix is inverted with exact wide integer
// arithmetic, and every row word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_3x4_top_test;
  import ami_pkg::*;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = 100;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  PAUSE_AT     = 150;
  localparam int  N_RANDOM     = 320;

  typedef struct packed {
    logic [1:0]                   row_index;
    logic [NUM_LANE-1:0][Q_W-1:0] val;
    logic                         singular;
    logic                         last_row;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ami_in_if  matrix ();
  ami_out_if result ();

  affine_matrix_inverse_3x4_top DUT (
    .clk    (clk),
    .rst    (rst),
    .matrix (matrix),
    .result (result)
  );

  always #2 clk = ~clk;

  mat_t pending_mats[$];
  row_t inverse_rows[$];
  int   n_sent     = 0;
  int   n_rows     = 0;
  int   n_errors   = 0;
  int   cycles     = 0;
  bit   paused     = 1'b0;
  bit   pause_done = 1'b0;
  bit   hold_done  = 1'b0;
  int   hold_left  = 0;

  // round num/den to nearest, halves away from zero, saturate to 32 bits
  function automatic logic [Q_W-1:0] round_sat(logic signed [255:0] num,
                                               logic signed [255:0] den);
    logic        neg;
    logic [255:0] nm, dm, q;
    neg = (num < 0) ^ (den < 0);
    nm  = (num < 0) ? -num : num;
    dm  = (den < 0) ? -den : den;
    q   = (2 * nm + dm) / (2 * dm);
    if (neg) begin
      if (q > 256'h8000_0000) return SAT_NEG;
      return -q[Q_W-1:0];
    end
    if (q > 256'h7FFF_FFFF) return SAT_POS;
    return q[Q_W-1:0];
  endfunction

  // exact cofactor inverse of one matrix, three rows queued
  function automatic void predict_inverse(mat_t m);
    logic signed [255:0] e[NUM_ENT];
    logic signed [255:0] cf[NUM_COF];
    logic signed [255:0] det, osum;
    row_t                r;
    for (int i = 0; i < NUM_ENT; i++) e[i] = $signed(m[i]);
    for (int i = 0; i < NUM_COF; i++)
      cf[i] = e[COF_IDX[i][0]] * e[COF_IDX[i][1]] - e[COF_IDX[i][2]] * e[COF_IDX[i][3]];
    det = 0;
    for (int k = 0; k < 3; k++) det += e[k] * cf[k*3];
    for (int row = 0; row < 3; row++) begin
      r = '0;
      r.row_index = row[1:0];
      r.last_row  = (row == 2);
      r.singular  = (det == 0);
      if (det != 0) begin
        osum = 0;
        for (int k = 0; k < 3; k++) begin
          r.val[k] = round_sat(cf[row*3+k] <<< (2 * FRAC_BITS), det);
          osum += e[k*4+3] * cf[row*3+k];
        end
        r.val[3] = round_sat(-(osum <<< FRAC_BITS), det);
      end
      inverse_rows.push_back(r);
    end
  endfunction

  function automatic logic [IN_W-1:0] rand_entry(int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom_range(32'h400) - 32'h200;
    endcase
  endfunction

  // random matrix: mostly well-scaled, some full range or singular
  function automatic mat_t rand_matrix();
    mat_t m;
    int   sel;
    sel = $urandom_range(99);
    for (int i = 0; i < NUM_ENT; i++)
      m[i] = rand_entry(sel < 20 ? 0 : (sel < 85 ? 1 : 2));
    if (sel >= 40 && sel < 60)
      for (int i = 0; i < 3; i++) m[i*5] = m[i*5] + 32'h0001_0000;
    if (sel >= 85 && sel < 95)
      for (int i = 0; i < 4; i++) m[8+i] = m[i];
    return m;
  endfunction

  function automatic mat_t diag(logic [IN_W-1:0] d0, logic [IN_W-1:0] d1,
                                logic [IN_W-1:0] d2, logic [IN_W-1:0] t0);
    mat_t m;
    m = '0;
    m[0] = d0; m[5] = d1; m[10] = d2; m[3] = t0;
    return m;
  endfunction

  // stimulus and end of run
  initial begin
    mat_t m;
    pending_mats.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0));
    pending_mats.push_back('0);
    pending_mats.push_back({NUM_ENT{32'h7FFF_FFFF}});
    pending_mats.push_back({NUM_ENT{32'h8000_0000}});
    pending_mats.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF));
    pending_mats.push_back(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    pending_mats.push_back(diag(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001));
    pending_mats.push_back(diag(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0003));
    pending_mats.push_back(diag(32'hFFFE_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFD));
    pending_mats.push_back(diag(32'h0000_0003, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0005));
    m = rand_matrix();
    for (int i = 0; i < 4; i++) m[4+i] = m[i];
    pending_mats.push_back(m);
    m = '0;
    m[1] = 32'h0001_0000; m[4] = 32'h0001_0000; m[10] = 32'hFFFF_0000;
    m[3] = 32'h8000_0000; m[7] = 32'h7FFF_FFFF; m[11] = 32'h0000_8000;
    pending_mats.push_back(m);
    for (int i = 0; i < N_RANDOM; i++) pending_mats.push_back(rand_matrix());

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_mats.size() == 0);
    @(posedge clk);
    wait (matrix.valid === 1'b0 && inverse_rows.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // matrix driver
  always @(posedge clk) begin
    mat_t m;
    bit   idle;
    int   sent;
    if (rst) begin
      matrix.valid <= 1'b0;
    end else begin
      sent = n_sent;
      if (matrix.valid && matrix.ready) begin
        m = pending_mats.pop_front();
        predict_inverse(m);
        sent = sent + 1;
        n_sent <= sent;
      end
      if (!pause_done && sent == PAUSE_AT) begin
        paused = 1'b1;
        if (inverse_rows.size() == 0) begin
          paused = 1'b0;
          pause_done <= 1'b1;
        end
      end
      if (!matrix.valid || matrix.ready) begin
        case (sent < 110 ? 0 : (sent < 220 ? 1 : 2))
          0: idle = ($urandom_range(99) < 19);
          1: idle = ($urandom_range(99) < 86);
          default: idle = 1'b0;
        endcase
        if (pending_mats.size() != 0 && !idle && !paused) begin
          m = pending_mats[0];
          matrix.valid <= 1'b1;
          matrix.a00 <= m[0];  matrix.a01 <= m[1];  matrix.a02 <= m[2];  matrix.a03 <= m[3];
          matrix.a10 <= m[4];  matrix.a11 <= m[5];  matrix.a12 <= m[6];  matrix.a13 <= m[7];
          matrix.a20 <= m[8];  matrix.a21 <= m[9];  matrix.a22 <= m[10]; matrix.a23 <= m[11];
        end else begin
          matrix.valid <= 1'b0;
        end
      end
    end
  end

  // row word monitor and receiver stalls
  always @(posedge clk) begin
    row_t exp_row;
    bit   stall;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        n_rows <= n_rows + 1;
        if (inverse_rows.size() == 0) begin
          $error("row word with no prediction waiting");
          n_errors++;
        end else begin
          exp_row = inverse_rows.pop_front();
          if (result.row_index !== exp_row.row_index) begin
            $error("row_index: expected %0d, got %0d", exp_row.row_index, result.row_index);
            n_errors++;
          end
          if (result.col0 !== exp_row.val[0]) begin
            $error("col0: expected %h, got %h", exp_row.val[0], result.col0);
            n_errors++;
          end
          if (result.col1 !== exp_row.val[1]) begin
            $error("col1: expected %h, got %h", exp_row.val[1], result.col1);
            n_errors++;
          end
          if (result.col2 !== exp_row.val[2]) begin
            $error("col2: expected %h, got %h", exp_row.val[2], result.col2);
            n_errors++;
          end
          if (result.offset !== exp_row.val[3]) begin
            $error("offset: expected %h, got %h", exp_row.val[3], result.offset);
            n_errors++;
          end
          if (result.singular !== exp_row.singular) begin
            $error("singular: expected %b, got %b", exp_row.singular, result.singular);
            n_errors++;
          end
          if (result.last_row !== exp_row.last_row) begin
            $error("last_row: expected %b, got %b", exp_row.last_row, result.last_row);
            n_errors++;
          end
        end
      end
      // one long hold-off so the pipeline backs up into the input
      if (!hold_done && n_rows >= 60) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        stall = 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        stall = 1'b1;
      end else begin
        case (n_sent < 110 ? 0 : (n_sent < 220 ? 1 : 2))
          0: stall = ($urandom_range(99) < 86);
          1: stall = ($urandom_range(99) < 19);
          default: stall = 1'b0;
        endcase
      end
      result.ready <= !stall;
    end
  end

endmodule

// ===== filelist.f =====
src/ami_pkg.sv
src/ami_in_if.sv
src/ami_out_if.sv
src/ami_cofactor.sv
src/ami_accum.sv
src/ami_row_seq.sv
src/ami_rdiv.sv
src/affine_matrix_inverse_3x4_top.sv
tb/sv/affine_matrix_inverse_3x4_top_test.sv
